// ===== src/lsg_pkg.sv =====
// Package: shared types and constants of the leapfrog grid stepper.
`default_nettype none
package lsg_pkg;
	localparam int GRID_LAST   = 255;
	localparam int IDX_BITS    = 8;
	localparam int ADDR_BITS   = 2 * IDX_BITS;
	localparam int SMP_BITS    = 16;
	localparam int COEF_BITS   = 16;
	localparam int CFG_IDX_BITS = 1;

	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_X = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEF_Y = 1'd1;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_STEP  = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	localparam logic [2:0] CAP_NONE = 3'd0;
	localparam logic [2:0] CAP_MID  = 3'd1;
	localparam logic [2:0] CAP_UP   = 3'd2;
	localparam logic [2:0] CAP_DN   = 3'd3;
	localparam logic [2:0] CAP_LF   = 3'd4;
	localparam logic [2:0] CAP_MUL  = 3'd5;

	typedef struct packed {
		logic [1:0]                 func;
		logic [IDX_BITS-1:0]        row;
		logic [IDX_BITS-1:0]        col;
		logic signed [SMP_BITS-1:0] real_in;
		logic signed [SMP_BITS-1:0] imag_in;
	} cmd_t;

	typedef struct packed {
		logic signed [SMP_BITS-1:0] real_out;
		logic signed [SMP_BITS-1:0] imag_out;
		logic                       step_done;
	} result_t;

	typedef struct packed {
		logic [2:0] cap;
		logic       neg;
	} stencil_ctl_t;
endpackage
`default_nettype wire

// ===== src/lsg_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module lsg_ram #(
	parameter int DW = 16,
	parameter int AW = 16
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [0:(1<<AW)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== src/lsg_stencil.sv =====
// Five-point stencil datapath: tap capture, weighted differences, rounding, saturation.
`default_nettype none
module lsg_stencil import lsg_pkg::*; (
	input  wire logic                        clk,
	input  wire stencil_ctl_t                ctl,
	input  wire logic signed [SMP_BITS-1:0]  src_rd,
	input  wire logic signed [SMP_BITS-1:0]  dst_rd,
	input  wire logic        [COEF_BITS-1:0] coef_x,
	input  wire logic        [COEF_BITS-1:0] coef_y,
	output logic signed      [SMP_BITS-1:0]  wb_data
);
	localparam int DW = SMP_BITS + 2;
	localparam int PW = DW + COEF_BITS + 1;
	localparam int LW = PW + 1 - 16;

	logic signed [SMP_BITS-1:0] mid_q, dst_q, up_q, dn_q, lf_q;
	logic signed [PW-1:0]       px_s1, py_s1;
	logic signed [DW-1:0]       dr, dc;
	logic signed [PW:0]         acc;
	logic signed [LW-1:0]       lap;
	logic signed [LW:0]         sum;

	assign dr = DW'(up_q) + DW'(dn_q) - (DW'(mid_q) <<< 1);
	assign dc = DW'(lf_q) + DW'(src_rd) - (DW'(mid_q) <<< 1);

	always_ff @(posedge clk) begin
		case (ctl.cap)
			CAP_MID: begin
				mid_q <= src_rd;
				dst_q <= dst_rd;
			end
			CAP_UP: up_q <= src_rd;
			CAP_DN: dn_q <= src_rd;
			CAP_LF: lf_q <= src_rd;
			CAP_MUL: begin
				px_s1 <= PW'($signed({1'b0, coef_x}) * dr);
				py_s1 <= PW'($signed({1'b0, coef_y}) * dc);
			end
			default: ;
		endcase
	end

	always_comb begin
		acc = (PW+1)'(px_s1) + (PW+1)'(py_s1) + (PW+1)'(32768);
		lap = acc[PW:16];
		if (ctl.neg) begin
			sum = (LW+1)'(dst_q) - (LW+1)'(lap);
		end else begin
			sum = (LW+1)'(dst_q) + (LW+1)'(lap);
		end
		if (sum > (LW+1)'(32767)) begin
			wb_data = 16'sh7fff;
		end else if (sum < -(LW+1)'(32768)) begin
			wb_data = 16'sh8000;
		end else begin
			wb_data = sum[SMP_BITS-1:0];
		end
	end
endmodule
`default_nettype wire

// ===== src/leapfrog_schrodinger_grid_step.sv =====
// Top level: command sequencer, grid memories and configuration registers.
`default_nettype none
// Holds a 256 x 256 complex Q1.15 grid in two RAMs (real, imaginary). A write
// completes at the accepting edge and the sequencer stays idle; read answers
// with a one-cycle strobe in the cycle right after the accepting edge. A step
// first sweeps all 65536 points zeroing the edges, then updates each of the
// 254 x 254 interior points twice, imaginary half then real half, each point
// passing through states RD0 to RD4, MUL and WB, since the five stencil taps
// come one per cycle through the single read port of the source RAM. A final
// DONE state carries the step_done strobe. busy is high throughout; results
// cannot be stalled.
module leapfrog_schrodinger_grid_step import lsg_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire cmd_t                    cmd,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_idx,
	input  wire logic [COEF_BITS-1:0]    cfg_data,
	output logic                         result_valid,
	output result_t                      result
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RDOUT = 4'd1;
	localparam logic [3:0] ST_CLR = 4'd2;
	localparam logic [3:0] ST_RD0 = 4'd3;
	localparam logic [3:0] ST_RD1 = 4'd4;
	localparam logic [3:0] ST_RD2 = 4'd5;
	localparam logic [3:0] ST_RD3 = 4'd6;
	localparam logic [3:0] ST_RD4 = 4'd7;
	localparam logic [3:0] ST_MUL = 4'd8;
	localparam logic [3:0] ST_WB = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	localparam logic [IDX_BITS-1:0] LAST = IDX_BITS'(GRID_LAST);
	localparam logic [IDX_BITS-1:0] LAST_IN = IDX_BITS'(GRID_LAST - 1);
	localparam logic [IDX_BITS-1:0] ONE = IDX_BITS'(1);

	logic [3:0]           state_q;
	logic                 pass_q;
	logic [IDX_BITS-1:0]  r_q, c_q;
	logic [COEF_BITS-1:0] coef_x_q, coef_y_q;

	logic                  accept, edge_pt;
	logic [ADDR_BITS-1:0]  ctr_addr, src_addr, cmd_addr;
	logic                  re_we, im_we;
	logic [ADDR_BITS-1:0]  re_waddr, im_waddr, re_raddr, im_raddr;
	logic [SMP_BITS-1:0]   re_wdata, im_wdata, re_rd, im_rd;
	logic signed [SMP_BITS-1:0] src_rd, dst_rd, wb_data;
	stencil_ctl_t          ctl;

	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE);
	assign cmd_addr = {cmd.row, cmd.col};
	assign ctr_addr = {r_q, c_q};
	assign edge_pt  = (r_q == '0) || (r_q == LAST) || (c_q == '0) || (c_q == LAST);

	always_comb begin
		unique case (state_q)
			ST_RD1:  src_addr = {r_q - ONE, c_q};
			ST_RD2:  src_addr = {r_q + ONE, c_q};
			ST_RD3:  src_addr = {r_q, c_q - ONE};
			ST_RD4:  src_addr = {r_q, c_q + ONE};
			default: src_addr = ctr_addr;
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_RD1:  ctl.cap = CAP_MID;
			ST_RD2:  ctl.cap = CAP_UP;
			ST_RD3:  ctl.cap = CAP_DN;
			ST_RD4:  ctl.cap = CAP_LF;
			ST_MUL:  ctl.cap = CAP_MUL;
			default: ctl.cap = CAP_NONE;
		endcase
		ctl.neg = pass_q;
	end

	assign src_rd = pass_q ? $signed(im_rd) : $signed(re_rd);
	assign dst_rd = pass_q ? $signed(re_rd) : $signed(im_rd);

	always_comb begin
		re_we = 1'b0;
		im_we = 1'b0;
		re_waddr = ctr_addr;
		im_waddr = ctr_addr;
		re_wdata = '0;
		im_wdata = '0;
		re_raddr = pass_q ? ctr_addr : src_addr;
		im_raddr = pass_q ? src_addr : ctr_addr;
		unique case (state_q)
			ST_IDLE: begin
				re_raddr = cmd_addr;
				im_raddr = cmd_addr;
				re_waddr = cmd_addr;
				im_waddr = cmd_addr;
				re_wdata = cmd.real_in;
				im_wdata = cmd.imag_in;
				re_we = accept && (cmd.func == FUNC_WRITE);
				im_we = re_we;
			end
			ST_CLR: begin
				re_we = edge_pt;
				im_we = edge_pt;
			end
			ST_WB: begin
				re_we = pass_q;
				im_we = !pass_q;
				re_wdata = wb_data;
				im_wdata = wb_data;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_x_q <= COEF_BITS'(8192);
			coef_y_q <= COEF_BITS'(8192);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_COEF_X: coef_x_q <= cfg_data;
				REG_COEF_Y: coef_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= 1'b0;
			r_q     <= '0;
			c_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && cmd.func == FUNC_READ) begin
						state_q <= ST_RDOUT;
					end else if (accept && cmd.func == FUNC_STEP) begin
						state_q <= ST_CLR;
						pass_q  <= 1'b0;
						r_q     <= '0;
						c_q     <= '0;
					end
				end
				ST_RDOUT: state_q <= ST_IDLE;
				ST_CLR: begin
					c_q <= c_q + ONE;
					if (c_q == LAST) begin
						r_q <= r_q + ONE;
						if (r_q == LAST) begin
							r_q <= ONE;
							c_q <= ONE;
							state_q <= ST_RD0;
						end
					end
				end
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: state_q <= ST_RD3;
				ST_RD3: state_q <= ST_RD4;
				ST_RD4: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_WB;
				ST_WB: begin
					state_q <= ST_RD0;
					c_q <= c_q + ONE;
					if (c_q == LAST_IN) begin
						c_q <= ONE;
						r_q <= r_q + ONE;
						if (r_q == LAST_IN) begin
							r_q <= ONE;
							if (pass_q) begin
								state_q <= ST_DONE;
							end else begin
								pass_q <= 1'b1;
							end
						end
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid     = (state_q == ST_RDOUT) || (state_q == ST_DONE);
	assign result.real_out  = (state_q == ST_RDOUT) ? $signed(re_rd) : '0;
	assign result.imag_out  = (state_q == ST_RDOUT) ? $signed(im_rd) : '0;
	assign result.step_done = (state_q == ST_DONE);

	lsg_ram #(.DW(SMP_BITS), .AW(ADDR_BITS)) u_ram_re (
		.clk(clk), .we(re_we), .waddr(re_waddr), .wdata(re_wdata),
		.raddr(re_raddr), .rdata(re_rd)
	);

	lsg_ram #(.DW(SMP_BITS), .AW(ADDR_BITS)) u_ram_im (
		.clk(clk), .we(im_we), .waddr(im_waddr), .wdata(im_wdata),
		.raddr(im_raddr), .rdata(im_rd)
	);

	lsg_stencil u_stencil (
		.clk(clk), .ctl(ctl), .src_rd(src_rd), .dst_rd(dst_rd),
		.coef_x(coef_x_q), .coef_y(coef_y_q), .wb_data(wb_data)
	);
endmodule
`default_nettype wire
